@@ sv/cls_pkg.sv @@
`default_nettype none

package cls_pkg;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int ARGS_W     = 11;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;

  localparam logic [CNT_W-1:0]  RUN_SAT   = 16'hFFFF;
  localparam logic [CNT_W-1:0]  SPENT_SAT = 16'hFFFF;
  localparam logic [ARGS_W-1:0] ARGS_SAT  = 11'h7FF;

  localparam logic [ARGS_W-1:0] MAX_ARGS_RST  = 11'd256;
  localparam logic [CNT_W-1:0]  MAX_BYTES_RST = 16'd32768;

  localparam logic [KIND_W-1:0] KIND_RUN      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_END = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 2'd1;

  // Results that one input byte causes, in delivery order.
  typedef struct packed {
    logic bs_run;
    logic ch;
    logic arg_end;
    logic line_end;
  } cls_flags_t;

  typedef struct packed {
    cls_flags_t        flags;
    logic [CNT_W-1:0]  run_rep;
    logic [BYTE_W-1:0] ch_byte;
    logic [ARGS_W-1:0] arg_total;
    logic              clip_run;
    logic              clip_rest;
  } cls_entry_t;

endpackage

`default_nettype wire

@@ sv/cls_in_if.sv @@
`default_nettype none

interface cls_in_if;
  import cls_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ sv/cls_out_if.sv @@
`default_nettype none

interface cls_out_if;
  import cls_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] out_byte;
  logic [CNT_W-1:0]  repeat_res;
  logic [ARGS_W-1:0] arg_total;
  logic              clipped;
  logic              last;

  modport source(output valid, output kind, output out_byte, output repeat_res,
                 output arg_total, output clipped, output last, input ready);
  modport sink(input valid, input kind, input out_byte, input repeat_res,
               input arg_total, input clipped, input last, output ready);
endinterface

`default_nettype wire

@@ sv/cls_cfg_if.sv @@
`default_nettype none

interface cls_cfg_if;
  import cls_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/command_line_splitter.sv @@
// An accepted byte's results go into the request queue, then into the output stage.
// Throughput: one byte per cycle while the request queue has room. The output
// presents one result at a time, so a byte causing up to three results holds it
// longer, the request queue between classifier and output absorbing the difference.
// Reset: synchronous active-low rst_n clears parser state and queue; limits
// return to 256 arguments and 32768 bytes. No clearing pass.
`default_nettype none

module command_line_splitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cls_in_if.sink    in_ch,
  cls_out_if.source out_ch,
  cls_cfg_if.sink   cfg_ch
);
  import cls_pkg::*;

  cls_entry_t push_data, pop_data;
  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;

  cls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  cls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ sv/cls_front.sv @@
`default_nettype none

module cls_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  cls_in_if.sink              in_ch,
  cls_cfg_if.sink             cfg_ch,
  output cls_pkg::cls_entry_t push_data,
  output logic                push_valid,
  input  wire logic           push_ready
);
  import cls_pkg::*;

  logic [ARGS_W-1:0] max_args_r;
  logic [CNT_W-1:0]  max_bytes_r;

  logic              in_arg_r, in_arg_nxt;
  logic              in_q_r, in_q_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [ARGS_W-1:0] args_r, args_nxt;
  logic [CNT_W-1:0]  spent_r, spent_nxt;
  logic              halted_r, halted_nxt;
  logic              drop_r, drop_nxt;

  logic [BYTE_W-1:0] c;
  logic              is_ws;
  logic              room_ok;
  logic [CNT_W-1:0]  avail;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  take1;
  logic              drop1;
  logic              fit2;
  logic              req2;
  logic [BYTE_W-1:0] ch2;
  logic              do_plain;
  logic              q_cur;
  logic              do_end;
  logic              do_line;
  logic              sat_drop;
  logic              v_ch;
  logic [CNT_W-1:0]  spent_k;
  logic              d1, d2;
  logic              accept;

  assign c      = in_ch.in_byte;
  assign is_ws  = (c == CH_SPACE) || (c == CH_TAB);
  assign accept = in_ch.valid && in_ch.ready;

  assign room_ok = ({1'b0, spent_r} + 17'd1) < {1'b0, max_bytes_r};
  assign avail   = room_ok ? (max_bytes_r - spent_r - 16'd1) : '0;

  always_comb begin
    in_arg_nxt = in_arg_r;
    in_q_nxt   = in_q_r;
    run_nxt    = run_r;
    args_nxt   = args_r;
    halted_nxt = halted_r;
    cnt        = '0;
    req2       = 1'b0;
    ch2        = c;
    do_plain   = 1'b0;
    q_cur      = in_q_r;
    do_end     = 1'b0;
    do_line    = 1'b0;
    sat_drop   = 1'b0;

    if (!in_arg_r) begin
      if (c == CH_NUL) begin
        do_line = 1'b1;
      end else if (halted_r || is_ws) begin
        // ignore
      end else if ((args_r >= max_args_r) || !room_ok) begin
        halted_nxt = 1'b1;
      end else begin
        if (args_r != ARGS_SAT) args_nxt = args_r + 11'd1;
        in_arg_nxt = 1'b1;
        in_q_nxt   = 1'b0;
        run_nxt    = '0;
        q_cur      = 1'b0;
        do_plain   = 1'b1;
      end
    end else if (run_r != '0) begin
      if (c == CH_BSLASH) begin
        if (run_r != RUN_SAT) run_nxt = run_r + 16'd1;
        else sat_drop = 1'b1;
      end else if (c == CH_QUOTE) begin
        run_nxt = '0;
        cnt     = {1'b0, run_r[CNT_W-1:1]};
        if (run_r[0]) begin
          req2 = 1'b1;
          ch2  = CH_QUOTE;
        end else begin
          in_q_nxt = ~in_q_r;
        end
      end else begin
        run_nxt  = '0;
        cnt      = run_r;
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (c == CH_BSLASH) begin
        run_nxt = 16'd1;
      end else if (c == CH_QUOTE) begin
        in_q_nxt = ~q_cur;
      end else if (c == CH_NUL) begin
        do_end  = 1'b1;
        do_line = 1'b1;
      end else if (is_ws && !q_cur) begin
        do_end = 1'b1;
      end else begin
        req2 = 1'b1;
        ch2  = c;
      end
    end
  end

  // The single-byte keep fits exactly when the run left room behind it.
  assign take1 = (cnt < avail) ? cnt : avail;
  assign drop1 = cnt > avail;
  assign fit2  = cnt < avail;
  assign v_ch  = req2 && fit2;
  assign d1    = drop_r || drop1;
  assign d2    = d1 || (req2 && !fit2);
  assign spent_k = spent_r + take1 + {{(CNT_W-1){1'b0}}, v_ch};

  always_comb begin
    spent_nxt = spent_k;
    drop_nxt  = d2 || sat_drop;
    if (do_end) begin
      if (spent_k != SPENT_SAT) spent_nxt = spent_k + 16'd1;
    end
  end

  always_comb begin
    push_data.flags.bs_run   = take1 != '0;
    push_data.flags.ch       = v_ch;
    push_data.flags.arg_end  = do_end;
    push_data.flags.line_end = do_line;
    push_data.run_rep        = take1;
    push_data.ch_byte        = ch2;
    push_data.arg_total      = args_r;
    push_data.clip_run       = d1 || halted_r;
    push_data.clip_rest      = d2 || halted_r;
  end

  assign push_valid   = accept && (push_data.flags != '0);
  assign in_ch.ready  = push_ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r  <= MAX_ARGS_RST;
      max_bytes_r <= MAX_BYTES_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_MAX_ARGS) max_args_r <= cfg_ch.data[ARGS_W-1:0];
      else if (cfg_ch.index == CFG_MAX_BYTES) max_bytes_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_arg_r <= 1'b0;
      in_q_r   <= 1'b0;
      run_r    <= '0;
      args_r   <= '0;
      spent_r  <= '0;
      halted_r <= 1'b0;
      drop_r   <= 1'b0;
    end else if (accept) begin
      if (do_line) begin
        in_arg_r <= 1'b0;
        in_q_r   <= 1'b0;
        run_r    <= '0;
        args_r   <= '0;
        spent_r  <= '0;
        halted_r <= 1'b0;
        drop_r   <= 1'b0;
      end else begin
        in_arg_r <= do_end ? 1'b0 : in_arg_nxt;
        in_q_r   <= do_end ? 1'b0 : in_q_nxt;
        run_r    <= do_end ? '0 : run_nxt;
        args_r   <= args_nxt;
        spent_r  <= spent_nxt;
        halted_r <= halted_nxt;
        drop_r   <= drop_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/cls_queue.sv @@
`default_nettype none

module cls_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push_valid,
  output logic                     push_ready,
  input  wire cls_pkg::cls_entry_t push_data,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output cls_pkg::cls_entry_t      pop_data
);
  import cls_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

  cls_entry_t        mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign push_ready = fill_r != FILL_FULL;
  assign pop_valid  = fill_r != '0;
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ sv/cls_back.sv @@
`default_nettype none

module cls_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire cls_pkg::cls_entry_t pop_data,
  cls_out_if.source                out_ch
);
  import cls_pkg::*;

  cls_entry_t cur_r;
  cls_flags_t mask_r;
  cls_flags_t first;
  cls_flags_t rest;
  logic       take_out;
  logic       need_load;

  // Pick the earliest pending result of the held request.
  always_comb begin
    first = '0;
    if (mask_r.bs_run) first.bs_run = 1'b1;
    else if (mask_r.ch) first.ch = 1'b1;
    else if (mask_r.arg_end) first.arg_end = 1'b1;
    else if (mask_r.line_end) first.line_end = 1'b1;
  end

  assign rest      = mask_r & ~first;
  assign take_out  = out_ch.valid && out_ch.ready;
  assign need_load = (mask_r == '0) || (take_out && (rest == '0));
  assign pop_ready = need_load;

  always_comb begin
    out_ch.kind       = KIND_RUN;
    out_ch.out_byte   = '0;
    out_ch.repeat_res = '0;
    out_ch.arg_total  = '0;
    out_ch.clipped    = cur_r.clip_rest;
    if (first.bs_run) begin
      out_ch.out_byte   = CH_BSLASH;
      out_ch.repeat_res = cur_r.run_rep;
      out_ch.clipped    = cur_r.clip_run;
    end else if (first.ch) begin
      out_ch.out_byte   = cur_r.ch_byte;
      out_ch.repeat_res = 16'd1;
    end else if (first.arg_end) begin
      out_ch.kind = KIND_ARG_END;
    end else if (first.line_end) begin
      out_ch.kind      = KIND_LINE_END;
      out_ch.arg_total = cur_r.arg_total;
    end
  end

  assign out_ch.valid = mask_r != '0;
  assign out_ch.last  = rest == '0;

  always_ff @(posedge clk) begin
    if (need_load && pop_valid) cur_r <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (need_load) begin
      mask_r <= pop_valid ? pop_data.flags : '0;
    end else if (take_out) begin
      mask_r <= rest;
    end
  end

endmodule

`default_nettype wire

@@ sv/cls_checker.sv @@
`default_nettype none

module cls_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  out_byte,
  input wire logic [15:0] repeat_res,
  input wire logic        last
);
  import cls_pkg::*;

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(repeat_res) && $stable(last))
    else $error("stalled result changed");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_RUN) |-> repeat_res != 16'd0)
    else $error("empty byte run");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind != KIND_RUN) |-> (out_byte == 8'd0) && (repeat_res == 16'd0))
    else $error("argument or line end carries run data");

  a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_LINE_END) |-> last)
    else $error("line end not last result of its byte");

endmodule

bind command_line_splitter cls_checker u_cls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .kind       (out_ch.kind),
  .out_byte   (out_ch.out_byte),
  .repeat_res (out_ch.repeat_res),
  .last       (out_ch.last)
);

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] ch;
    logic [CNT_W-1:0]  rep;
    logic [ARGS_W-1:0] total;
    logic              clipped;
    logic              last;
  } token_t;

  // Tracks the argument splitter and holds the tokens still owed by the block.
  class argv_tracker;
    bit [ARGS_W-1:0] args_limit;
    bit [CNT_W-1:0]  bytes_limit;
    bit              in_arg;
    bit              quoted;
    bit              halted;
    bit              dropped;
    int unsigned     bs_count;
    int unsigned     arg_count;
    int unsigned     spent;
    token_t          pending[$];
    int              errors;
    int              live_bytes;

    function new();
      args_limit  = MAX_ARGS_RST;
      bytes_limit = MAX_BYTES_RST;
      errors      = 0;
      live_bytes  = 0;
      clear_line();
    endfunction

    function void clear_line();
      in_arg    = 1'b0;
      quoted    = 1'b0;
      halted    = 1'b0;
      dropped   = 1'b0;
      bs_count  = 0;
      arg_count = 0;
      spent     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MAX_ARGS) begin
        args_limit = data[ARGS_W-1:0];
      end else if (idx == CFG_MAX_BYTES) begin
        bytes_limit = data[CNT_W-1:0];
      end
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] ch, int unsigned rep,
                       int unsigned total);
      token_t t;
      t.kind    = kind;
      t.ch      = ch;
      t.rep     = rep[CNT_W-1:0];
      t.total   = total[ARGS_W-1:0];
      t.clipped = dropped | halted;
      t.last    = 1'b0;
      pending.push_back(t);
    endfunction

    function void keep_text(logic [BYTE_W-1:0] ch, int unsigned count);
      int unsigned avail;
      int unsigned take;
      avail = (spent + 1 < bytes_limit) ? bytes_limit - 1 - spent : 0;
      take  = (count < avail) ? count : avail;
      if (take < count) dropped = 1'b1;
      if (take == 0) return;
      spent += take;
      push(KIND_RUN, ch, take, 0);
    endfunction

    function void close_arg();
      if (spent < SPENT_SAT) spent++;
      in_arg   = 1'b0;
      quoted   = 1'b0;
      bs_count = 0;
      push(KIND_ARG_END, 8'h00, 0, 0);
    endfunction

    function void close_line();
      push(KIND_LINE_END, 8'h00, 0, arg_count);
      clear_line();
    endfunction

    function void plain(logic [BYTE_W-1:0] c);
      if (c == CH_BSLASH) begin
        bs_count = 1;
      end else if (c == CH_QUOTE) begin
        quoted = !quoted;
      end else if (c == CH_NUL) begin
        close_arg();
        close_line();
      end else if ((c == CH_SPACE || c == CH_TAB) && !quoted) begin
        close_arg();
      end else begin
        keep_text(c, 1);
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] c);
      int unsigned n;
      int          base;
      token_t      tail;
      base = pending.size();
      live_bytes++;
      if (!in_arg && c != CH_NUL && (halted || c == CH_SPACE || c == CH_TAB)) begin
        return;
      end
      if (!in_arg) begin
        if (c == CH_NUL) begin
          close_line();
        end else if (arg_count >= args_limit || spent + 1 >= bytes_limit) begin
          halted = 1'b1;
        end else begin
          if (arg_count < ARGS_SAT) arg_count++;
          in_arg   = 1'b1;
          quoted   = 1'b0;
          bs_count = 0;
          plain(c);
        end
      end else if (bs_count != 0) begin
        n = bs_count;
        if (c == CH_BSLASH) begin
          if (n < RUN_SAT) bs_count = n + 1;
          else dropped = 1'b1;
        end else if (c == CH_QUOTE) begin
          bs_count = 0;
          keep_text(CH_BSLASH, n >> 1);
          if (n[0]) keep_text(CH_QUOTE, 1);
          else quoted = !quoted;
        end else begin
          bs_count = 0;
          keep_text(CH_BSLASH, n);
          plain(c);
        end
      end else begin
        plain(c);
      end
      // mark the final token of this byte
      if (pending.size() > base) begin
        tail = pending.pop_back();
        tail.last = 1'b1;
        pending.push_back(tail);
      end
    endfunction

    function void diff(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(token_t got);
      token_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d byte %0d rep %0d",
                 $time, got.kind, got.ch, got.rep);
        return;
      end
      want = pending.pop_front();
      diff("kind", want.kind, got.kind);
      diff("out_byte", want.ch, got.ch);
      diff("repeat_res", want.rep, got.rep);
      diff("arg_total", want.total, got.total);
      diff("clipped", want.clipped, got.clipped);
      diff("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps;
  argv_tracker board;

  cls_in_if  in_ch();
  cls_out_if out_ch();
  cls_cfg_if cfg_ch();

  command_line_splitter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] line_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_SPACE;
    if (r < 15) return CH_TAB;
    if (r < 30) return CH_QUOTE;
    if (r < 50) return CH_BSLASH;
    if (r < 85) return 8'($urandom_range(8'h21, 8'h7E));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] c);
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    board.note_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_reg(idx, data);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic retune(input logic [CFG_DATA_W-1:0] args_val,
                        input logic [CFG_DATA_W-1:0] bytes_val);
    settle();
    write_reg(CFG_MAX_ARGS, args_val);
    write_reg(CFG_MAX_BYTES, bytes_val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_lines(input int quota);
    int  start;
    int  len;
    bit  noise;
    start = board.live_bytes;
    no_gaps = ($urandom_range(0, 3) == 0);
    while (board.live_bytes - start < quota) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      noise = ($urandom_range(0, 5) == 0);
      for (int i = 0; i < len; i++) begin
        send_byte(noise ? 8'($urandom_range(0, 255)) : line_char());
      end
      // leave a line open now and then
      if ($urandom_range(0, 9) != 0) send_byte(CH_NUL);
    end
  endtask

  initial begin : result_sink
    int     stall;
    token_t got;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.kind    = out_ch.kind;
        got.ch      = out_ch.out_byte;
        got.rep     = out_ch.repeat_res;
        got.total   = out_ch.arg_total;
        got.clipped = out_ch.clipped;
        got.last    = out_ch.last;
        board.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_gaps) stall = gap_len();
      end
    end
  end

  initial begin : stimulus
    board = new();
    no_gaps = 1'b0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_MAX_ARGS;
    cfg_ch.data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // separators, quoted space, odd and even backslash runs before a quote, empty argument
    send_text(" \ta\" \"\\\\\\\"\\\\\"\"\t\"\" ");
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(CH_BSLASH);
    send_byte("z");
    // flush a pending run at the line end
    send_byte(CH_BSLASH);
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_text("\"q\x7F");
    send_byte(CH_NUL);
    random_lines(35);

    retune(16'd1, 16'hFFFF);
    // second argument hits the limit and halts the line
    send_text("ab cd");
    send_byte(CH_NUL);
    random_lines(30);

    retune(16'd1024, 16'd2);
    random_lines(30);

    retune(16'd3, 16'd20);
    random_lines(35);

    retune(16'd6, 16'd45);
    random_lines(35);

    // upper bits of max_args are dropped, leaving zero
    settle();
    write_reg(CFG_MAX_ARGS, 16'hF800);
    write_reg(CFG_MAX_BYTES, 16'd1);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5A5A);
    cfg_ch.valid <= 1'b0;
    random_lines(15);

    retune(16'hFFFF, 16'd0);
    random_lines(15);

    // long odd backslash run closed by a quote
    retune(16'd1024, 16'hFFFF);
    no_gaps = 1'b1;
    send_byte("s");
    for (int i = 0; i < 9; i++) send_byte(CH_BSLASH);
    send_byte(CH_QUOTE);
    send_byte(CH_NUL);
    random_lines(25);

    settle();
    if (board.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
